// ===== rtl/tfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types and constants of the tagged frame receiver.
// ----------------------------------------------------------------------------
package tfr_pkg;

   localparam int FRAME_BYTES = 14;
   localparam int LAST_POS    = FRAME_BYTES - 1;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int NUM_FIELDS  = 4;
   // each field is a tag byte followed by a big-endian word, first tag at byte 1
   localparam int FIELD_BASE   = 1;
   localparam int FIELD_STRIDE = 3;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HEADER_ERR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TAIL_ERR   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_HEADER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TAIL   = 2'd1;

   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hD8;
   localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'hEE;

   localparam logic [BYTE_W-1:0] TAG_LEFT     = 8'hB0;
   localparam logic [BYTE_W-1:0] TAG_RIGHT    = 8'hB1;
   localparam logic [BYTE_W-1:0] TAG_POSITION = 8'hB2;
   localparam logic [BYTE_W-1:0] TAG_INFO     = 8'hB3;

   localparam logic [BYTE_W-1:0] FIELD_TAG [NUM_FIELDS] =
      '{TAG_LEFT, TAG_RIGHT, TAG_POSITION, TAG_INFO};

   typedef struct packed {
      logic [BYTE_W-1:0] header;
      logic [BYTE_W-1:0] tail;
   } tfr_cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0]                 status;
      logic [NUM_FIELDS-1:0]               update;
      logic [NUM_FIELDS-1:0][WORD_W-1:0]   word;
   } tfr_cmd_type;

endpackage

// ===== rtl/tfr_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_req_if
// Received byte channel.
// ----------------------------------------------------------------------------
interface tfr_req_if import tfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/tfr_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_rsp_if
// Frame result channel: status and the four held values.
// ----------------------------------------------------------------------------
interface tfr_rsp_if import tfr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [WORD_W-1:0] left_count;
   logic signed [WORD_W-1:0] right_count;
   logic signed [WORD_W-1:0] position_value;
   logic signed [WORD_W-1:0] info_value;

   modport source (output valid, output status, output left_count, output right_count,
                   output position_value, output info_value, input ready);
   modport sink (input valid, input status, input left_count, input right_count,
                 input position_value, input info_value, output ready);
endinterface

// ===== rtl/tfr_csr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface tfr_csr_if import tfr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [BYTE_W-1:0]      wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/tfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_front
// Byte collector: tracks the frame position, checks header and tail and
// hands one command per finished frame or header error to the queue.
// ----------------------------------------------------------------------------
module tfr_front import tfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tfr_req_if.sink     req_bus,
   input  tfr_cfg_type cfg,
   input  logic        push_ready,
   output logic        push_valid,
   output tfr_cmd_type push_cmd
);

   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   logic [BYTE_W-1:0] store_ff [1:LAST_POS-1];
   logic              accept;
   logic              at_head;
   logic              at_tail;
   logic              header_ok;
   logic              tail_ok;

   assign req_bus.ready = push_ready;
   assign accept        = req_bus.valid & push_ready;
   assign at_head       = (pos_ff == '0);
   assign at_tail       = (pos_ff == POS_W'(LAST_POS));
   assign header_ok     = (req_bus.rx_byte == cfg.header);
   assign tail_ok       = (req_bus.rx_byte == cfg.tail);
   assign push_valid    = accept & ((at_head & ~header_ok) | at_tail);

   always_comb begin
      push_cmd.status = at_head ? STATUS_HEADER_ERR : (tail_ok ? STATUS_OK : STATUS_TAIL_ERR);
      for (int k = 0; k < NUM_FIELDS; k++) begin
         push_cmd.update[k] = at_tail & tail_ok &
            (store_ff[FIELD_BASE + FIELD_STRIDE * k] == FIELD_TAG[k]);
         push_cmd.word[k] = {store_ff[FIELD_BASE + FIELD_STRIDE * k + 1],
                             store_ff[FIELD_BASE + FIELD_STRIDE * k + 2]};
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (at_head) begin
            pos_in = header_ok ? POS_W'(1) : '0;
         end else if (at_tail) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // header and tail bytes are never stored, only compared
   always_ff @(posedge clock) begin
      for (int i = 1; i < LAST_POS; i++) begin
         if (accept && pos_ff == POS_W'(i)) begin
            store_ff[i] <= req_bus.rx_byte;
         end
      end
   end

endmodule

// ===== rtl/tfr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_queue
// Short command queue between the byte collector and the result stage.
// ----------------------------------------------------------------------------
module tfr_queue import tfr_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  tfr_cmd_type push_cmd,
   output logic        push_ready,
   output logic        pop_valid,
   output tfr_cmd_type pop_cmd,
   input  logic        pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tfr_cmd_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             take;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign take       = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, take})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("command pushed into a full queue");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (push && !take) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count did not follow a push");

endmodule

// ===== rtl/tfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_back
// Result stage: applies tag updates to the held values and drives the
// result register.
// ----------------------------------------------------------------------------
module tfr_back import tfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  tfr_cmd_type cmd,
   output logic        cmd_pop,
   tfr_rsp_if.source   rsp_bus
);

   logic                valid_ff;
   logic                valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [WORD_W-1:0]   held_ff [NUM_FIELDS];

   // the presented values are the held ones; they only move when the slot frees
   assign cmd_pop  = cmd_valid & (~valid_ff | rsp_bus.ready);
   assign valid_in = cmd_pop | (valid_ff & ~rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int k = 0; k < NUM_FIELDS; k++) begin
            held_ff[k] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         for (int k = 0; k < NUM_FIELDS; k++) begin
            if (cmd_pop && cmd.update[k]) begin
               held_ff[k] <= cmd.word[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         status_ff <= cmd.status;
      end
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.left_count     = held_ff[0];
   assign rsp_bus.right_count    = held_ff[1];
   assign rsp_bus.position_value = held_ff[2];
   assign rsp_bus.info_value     = held_ff[3];

   a_held_quiet : assert property (@(posedge clock) disable iff (reset)
      !cmd_pop |=> ($stable(held_ff[0]) && $stable(held_ff[1]) &&
                    $stable(held_ff[2]) && $stable(held_ff[3])))
      else $error("held value changed without a command");

   a_error_no_update : assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.status != STATUS_OK) |-> cmd.update == '0)
      else $error("error item carries a value update");

   a_status_legal : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (status_ff == STATUS_OK || status_ff == STATUS_HEADER_ERR ||
                    status_ff == STATUS_TAIL_ERR))
      else $error("result status out of range");

endmodule

// ===== rtl/tagged_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_frame_receiver
// Collects 14-byte tagged frames, checks header and tail bytes and keeps four
// signed 16-bit values updated from matching tags.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_bus   in         rx_byte
//  rsp_bus   out        status, left_count, right_count, position_value, info_value
//  csr_bus   in         index, wdata (0 header byte, 1 tail byte)
//
//  one byte accepted per cycle unless the queue is full; a frame's last byte or a
//  failed header byte gives a result through the queue, then the result register
//  req_bus.ready drops only when the command queue is full, which happens
//  only while rsp_bus is stalled
//  synchronous reset clears the frame position, the held values and the queue;
//  no clearing pass, the block takes bytes in the first cycle after reset
//  csr_bus is always ready
// ----------------------------------------------------------------------------
module tagged_frame_receiver import tfr_pkg::*; #(
   parameter int QUEUE_DEPTH = 2  // 2 or more
) (
   input  logic      clock,
   input  logic      reset,
   tfr_req_if.sink   req_bus,
   tfr_rsp_if.source rsp_bus,
   tfr_csr_if.sink   csr_bus
);

   tfr_cfg_type cfg_ff;
   tfr_cmd_type push_cmd;
   tfr_cmd_type pop_cmd;
   logic        push_valid;
   logic        push_ready;
   logic        pop_valid;
   logic        pop;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header <= HEADER_RESET;
         cfg_ff.tail   <= TAIL_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_HEADER: cfg_ff.header <= csr_bus.wdata;
            REG_TAIL:   cfg_ff.tail   <= csr_bus.wdata;
            default:    ;
         endcase
      end
   end

   tfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   tfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   tfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_pop   (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== bench/tb_tagged_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tagged_frame_receiver
// Self-checking bench for the tagged frame receiver. A queue-fed driver sends
// received bytes: a few hand-picked frames first, then random traffic that is
// mostly well-formed frames, mixed with stray bytes, cut-short frames and bad
// tails. Every accepted byte runs through a local frame decoder. The result
// monitor compares each result with the oldest predicted one. Header and tail
// registers are rewritten between phases while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_tagged_frame_receiver;
   import tfr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [WORD_W-1:0] left_count;
      logic signed [WORD_W-1:0] right_count;
      logic signed [WORD_W-1:0] position_value;
      logic signed [WORD_W-1:0] info_value;
   } frame_result_t;

   logic clock = 1'b0;
   logic reset;

   tfr_req_if req_if ();
   tfr_rsp_if rsp_if ();
   tfr_csr_if csr_if ();

   tagged_frame_receiver dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stimulus and expected results
   logic [BYTE_W-1:0] rx_bytes_pending [$];
   frame_result_t     expected_results [$];

   // decoder copy of the block state
   logic [BYTE_W-1:0] cfg_header;
   logic [BYTE_W-1:0] cfg_tail;
   int                frame_pos;
   logic [BYTE_W-1:0] frame_bytes [FRAME_BYTES];
   logic [WORD_W-1:0] held_word [NUM_FIELDS];

   // values the generator builds frames for
   logic [BYTE_W-1:0] gen_header;
   logic [BYTE_W-1:0] gen_tail;

   int send_idle_pct;
   int recv_stall_pct;
   int cycle_count;
   int mismatches;
   int bytes_accepted;
   int results_checked;
   int ok_count;
   int header_err_count;
   int tail_err_count;

   function automatic void absorb_rx_byte(input logic [BYTE_W-1:0] b);
      frame_result_t       r;
      logic [STATUS_W-1:0] st;
      bit                  give;
      int                  f;
      int                  at;
      give = 1'b0;
      st   = STATUS_OK;
      if (frame_pos >= FRAME_BYTES) frame_pos = 0;
      frame_bytes[frame_pos] = b;
      if (frame_pos == 0 && b != cfg_header) begin
         st   = STATUS_HEADER_ERR;
         give = 1'b1;
      end else begin
         frame_pos++;
         if (frame_pos == FRAME_BYTES) begin
            frame_pos = 0;
            give      = 1'b1;
            if (frame_bytes[LAST_POS] != cfg_tail) begin
               st = STATUS_TAIL_ERR;
            end else begin
               for (f = 0; f < NUM_FIELDS; f++) begin
                  at = FIELD_BASE + FIELD_STRIDE * f;
                  if (frame_bytes[at] == FIELD_TAG[f])
                     held_word[f] = {frame_bytes[at + 1], frame_bytes[at + 2]};
               end
            end
         end
      end
      if (give) begin
         r.status         = st;
         r.left_count     = held_word[0];
         r.right_count    = held_word[1];
         r.position_value = held_word[2];
         r.info_value     = held_word[3];
         expected_results.push_back(r);
      end
   endfunction

   // byte driver, also tracks register writes and feeds the decoder
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         cfg_header   = HEADER_RESET;
         cfg_tail     = TAIL_RESET;
         frame_pos    = 0;
         for (int i = 0; i < FRAME_BYTES; i++) frame_bytes[i] = '0;
         for (int i = 0; i < NUM_FIELDS; i++) held_word[i] = '0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               REG_HEADER: begin
                  cfg_header = csr_if.wdata;
               end
               REG_TAIL: begin
                  cfg_tail = csr_if.wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            absorb_rx_byte(req_if.rx_byte);
            bytes_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (rx_bytes_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_if.valid   <= 1'b1;
               req_if.rx_byte <= rx_bytes_pending.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      frame_result_t want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: unexpected result status %0d left %0d right %0d pos %0d info %0d",
                           $time, rsp_if.status, rsp_if.left_count, rsp_if.right_count,
                           rsp_if.position_value, rsp_if.info_value);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               case (want.status)
                  STATUS_OK:         ok_count++;
                  STATUS_HEADER_ERR: header_err_count++;
                  default:           tail_err_count++;
               endcase
               if (rsp_if.status !== want.status || rsp_if.left_count !== want.left_count ||
                   rsp_if.right_count !== want.right_count ||
                   rsp_if.position_value !== want.position_value ||
                   rsp_if.info_value !== want.info_value) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("%0t: result %0d expected status %0d left %0d right %0d pos %0d info %0d",
                              $time, results_checked, want.status, want.left_count,
                              want.right_count, want.position_value, want.info_value);
                     $display("%0t: result %0d actual   status %0d left %0d right %0d pos %0d info %0d",
                              $time, results_checked, rsp_if.status, rsp_if.left_count,
                              rsp_if.right_count, rsp_if.position_value, rsp_if.info_value);
                  end
               end
            end
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, expected_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   // any byte other than the given one
   function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] v);
      return v ^ BYTE_W'($urandom_range(1, 255));
   endfunction

   task automatic queue_frame(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] tl,
                              input logic [NUM_FIELDS-1:0] tag_hit,
                              input logic [NUM_FIELDS-1:0][WORD_W-1:0] words);
      int f;
      rx_bytes_pending.push_back(hdr);
      for (f = 0; f < NUM_FIELDS; f++) begin
         rx_bytes_pending.push_back(tag_hit[f] ? FIELD_TAG[f] : other_than(FIELD_TAG[f]));
         rx_bytes_pending.push_back(words[f][15:8]);
         rx_bytes_pending.push_back(words[f][7:0]);
      end
      rx_bytes_pending.push_back(tl);
   endtask

   task automatic queue_random_frame(input bit good_tail);
      logic [NUM_FIELDS-1:0]             hits;
      logic [NUM_FIELDS-1:0][WORD_W-1:0] words;
      int f;
      for (f = 0; f < NUM_FIELDS; f++) begin
         hits[f]  = ($urandom_range(0, 99) < 75);
         words[f] = pick_word();
      end
      queue_frame(gen_header, good_tail ? gen_tail : other_than(gen_tail), hits, words);
   endtask

   task automatic queue_random_traffic(input int n_bytes);
      int start;
      int k;
      int pick;
      start = rx_bytes_pending.size() + bytes_accepted;
      while (rx_bytes_pending.size() + bytes_accepted - start < n_bytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            queue_random_frame(1'b1);
         end else if (pick < 84) begin
            // stray bytes between frames
            k = $urandom_range(1, 3);
            repeat (k) rx_bytes_pending.push_back(BYTE_W'($urandom));
         end else if (pick < 93) begin
            // frame cut short, the next bytes continue it
            rx_bytes_pending.push_back(gen_header);
            k = $urandom_range(1, LAST_POS - 1);
            repeat (k) rx_bytes_pending.push_back(BYTE_W'($urandom));
         end else begin
            queue_random_frame(1'b0);
         end
      end
   endtask

   // wait until every queued item is in and every result has come out
   task automatic wait_drained();
      do @(posedge clock);
      while (rx_bytes_pending.size() != 0 || req_if.valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= val;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_frame_bytes(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] tl);
      write_reg(REG_HEADER, hdr);
      write_reg(REG_TAIL, tl);
      gen_header = hdr;
      gen_tail   = tl;
   endtask

   initial begin
      logic [BYTE_W-1:0] v;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.rx_byte   = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = '0;
      csr_if.wdata     = '0;
      gen_header       = HEADER_RESET;
      gen_tail         = TAIL_RESET;
      send_idle_pct    = 30;
      recv_stall_pct   = 30;
      cycle_count      = 0;
      mismatches       = 0;
      bytes_accepted   = 0;
      results_checked  = 0;
      ok_count         = 0;
      header_err_count = 0;
      tail_err_count   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset values: stray byte, full frame of extreme words with header and
      // tail values inside the data, then a frame with two missed tags
      rx_bytes_pending.push_back(8'h00);
      queue_frame(HEADER_RESET, TAIL_RESET, 4'b1111,
                  {16'hFFFF, 16'hD8EE, 16'h7FFF, 16'h8000});
      queue_frame(HEADER_RESET, TAIL_RESET, 4'b1100,
                  {16'h0001, 16'hEED8, 16'h1234, 16'h5678});
      queue_random_traffic(110);
      wait_drained();

      set_frame_bytes(8'h00, 8'hFF);
      queue_random_traffic(60);
      // hold the sender until everything has come back
      wait_drained();
      queue_random_traffic(60);
      wait_drained();

      // long stretch with no idling on either side
      set_frame_bytes(8'hFF, 8'h00);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_random_traffic(120);
      wait_drained();

      send_idle_pct  = 30;
      recv_stall_pct = 30;
      v = BYTE_W'($urandom);
      set_frame_bytes(v, v);
      // unused register indexes must leave both bytes alone
      write_reg(2'd2, BYTE_W'($urandom));
      write_reg(2'd3, BYTE_W'($urandom));
      queue_random_traffic(120);
      wait_drained();

      set_frame_bytes(BYTE_W'($urandom), BYTE_W'($urandom));
      queue_random_traffic(130);
      wait_drained();

      set_frame_bytes(HEADER_RESET, TAIL_RESET);
      queue_random_traffic(130);
      wait_drained();
      repeat (10) @(posedge clock);

      if (expected_results.size() != 0) begin
         mismatches += expected_results.size();
         $display("%0d expected results never arrived", expected_results.size());
      end
      $display("covered %0d bytes, %0d results: %0d good frames, %0d header errors, %0d tail errors",
               bytes_accepted, results_checked, ok_count, header_err_count, tail_err_count);
      $display("six register settings, %0d mismatching results", mismatches);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
